// ===== design/tlrs_pkg.sv =====
package tlrs_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_BITS = 4;
    localparam int CNT_BITS  = 5;
    localparam int TIME_BITS = 16;
    localparam int Q_BITS    = 8;
    localparam int PC_BITS   = 5;

    // configuration register indexes
    localparam logic REG_QUANTUM = 1'b0;
    localparam logic REG_PCOUNT  = 1'b1;

    typedef logic [MAX_SLOTS-1:0][SLOT_BITS-1:0] slot_list_t;

    // controller -> datapath
    typedef struct packed {
        logic cap;        // capture input beat
        logic load;       // apply a slot load
        logic scan_init;  // start admission scan
        logic scan_late;  // scan against tick_now + 1
        logic scan_step;  // examine one slot
        logic rr_run;     // run the round-robin head
        logic min_init;   // start shortest-remaining search
        logic min_step;   // examine one lower-level entry
        logic low_run;    // run the chosen lower-level entry
        logic upd;        // list and slice bookkeeping
        logic res;        // write a run result
        logic res_idle;   // write an idle result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic scan_hit;
        logic scan_end;
        logic rr_any;
        logic low_any;
        logic slice_hit;
        logic min_end;
        logic out_free;
    } status_t;

endpackage

// ===== design/tlrs_ctrl.sv =====
module tlrs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tlrs_pkg::status_t st,
    output tlrs_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_ADM, ST_SEL, ST_RR, ST_ADM2,
        ST_MIN, ST_LOW, ST_UPD, ST_RES, ST_IDLERES
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap = 1'b1;
                    if (st.is_tick) begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_ADM;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ADM: begin
                cmd.scan_step = 1'b1;
                if (st.scan_hit || st.scan_end) state_next = ST_SEL;
            end
            ST_SEL: begin
                if (st.rr_any) begin
                    state_next = ST_RR;
                end else if (st.low_any) begin
                    cmd.min_init = 1'b1;
                    state_next   = ST_MIN;
                end else begin
                    state_next = ST_IDLERES;
                end
            end
            ST_RR: begin
                cmd.rr_run = 1'b1;
                if (st.slice_hit) begin
                    cmd.scan_init = 1'b1;
                    cmd.scan_late = 1'b1;
                    state_next    = ST_ADM2;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_ADM2: begin
                cmd.scan_step = 1'b1;
                if (st.scan_hit || st.scan_end) state_next = ST_UPD;
            end
            ST_MIN: begin
                if (st.min_end) begin
                    state_next = ST_LOW;
                end else begin
                    cmd.min_step = 1'b1;
                end
            end
            ST_LOW: begin
                cmd.low_run = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_RES;
            end
            ST_RES: begin
                if (st.out_free) begin
                    cmd.res    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLERES: begin
                if (st.out_free) begin
                    cmd.res_idle = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/tlrs_datapath.sv =====
module tlrs_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [39:0]                      s_tdata,
    input  logic                             s_tuser,
    output logic [39:0]                      m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic                             cfg_addr,
    input  logic [tlrs_pkg::Q_BITS-1:0]      cfg_wdata,
    input  tlrs_pkg::cmd_t                   cmd,
    output tlrs_pkg::status_t                st
);

    localparam int SB = tlrs_pkg::SLOT_BITS;
    localparam int CB = tlrs_pkg::CNT_BITS;
    localparam int TB = tlrs_pkg::TIME_BITS;
    localparam int QB = tlrs_pkg::Q_BITS;
    localparam int NS = tlrs_pkg::MAX_SLOTS;

    // drop entry idx, shifting later entries down
    function automatic tlrs_pkg::slot_list_t drop_at(input tlrs_pkg::slot_list_t l,
                                                      input logic [SB-1:0] idx);
        tlrs_pkg::slot_list_t r;
        r = l;
        for (int k = 0; k < NS - 1; k++) begin
            if (k >= int'(idx)) r[k] = l[k+1];
        end
        return r;
    endfunction

    // first position of a slot in a list, with match flag
    function automatic logic [SB:0] find_slot(input tlrs_pkg::slot_list_t l,
                                              input logic [CB-1:0] cnt,
                                              input logic [SB-1:0] slot);
        logic [SB:0] r;
        r = '0;
        for (int k = NS - 1; k >= 0; k--) begin
            if (k < int'(cnt) && l[k] == slot) r = {1'b1, SB'(k)};
        end
        return r;
    endfunction

    // slot stores
    logic [TB-1:0] arr_mem [NS];
    logic [TB-1:0] bur_mem [NS];
    logic [TB-1:0] rem_mem [NS];

    logic [NS-1:0]        mask_reg;
    tlrs_pkg::slot_list_t rr_list_reg, lo_list_reg;
    logic [CB-1:0]        rr_cnt_reg, lo_cnt_reg;
    logic [QB-1:0]        slice_reg;
    logic                 forced_reg, lran_reg;
    logic [TB-1:0]        tick_reg;
    logic [QB-1:0]        tq_reg;
    logic [tlrs_pkg::PC_BITS-1:0] pc_reg;

    // captured beat
    logic [SB-1:0] in_slot_reg;
    logic [TB-1:0] in_arr_reg, in_bur_reg;

    // scan and run bookkeeping
    logic [SB-1:0] scan_idx_reg;
    logic          late_reg;
    logic [CB-1:0] min_idx_reg;
    logic [SB-1:0] best_idx_reg;
    logic [TB-1:0] best_val_reg;
    logic [SB-1:0] run_slot_reg;
    logic          done_reg, from_low_reg, shit_reg;

    logic [39:0]   out_reg;
    logic          m_valid_reg;

    // effective slot count
    logic [CB-1:0] n_eff;
    assign n_eff = (pc_reg > CB'(NS)) ? CB'(NS) : pc_reg;

    // admission scan test
    logic [TB:0]   t_cmp;
    logic          scan_in;
    logic [TB-1:0] scan_arr, scan_rem;
    assign t_cmp    = {1'b0, tick_reg} + {{TB{1'b0}}, late_reg};
    assign scan_in  = ({1'b0, scan_idx_reg} < n_eff);
    assign scan_arr = arr_mem[scan_idx_reg];
    assign scan_rem = rem_mem[scan_idx_reg];

    // remaining-time read address
    logic [SB-1:0] rem_addr;
    logic [TB-1:0] rem_rd;
    always_comb begin
        rem_addr = rr_list_reg[0];
        if (cmd.min_init) begin
            rem_addr = lo_list_reg[0];
        end else if (cmd.min_step) begin
            rem_addr = lo_list_reg[min_idx_reg[SB-1:0]];
        end else if (cmd.low_run) begin
            rem_addr = lo_list_reg[best_idx_reg];
        end
    end
    assign rem_rd = rem_mem[rem_addr];

    // run step: quantum, decrement, finish
    logic          forced_eff;
    logic [QB-1:0] q_eff;
    logic [TB-1:0] rem_dec;
    assign forced_eff = forced_reg | (cmd.rr_run & lran_reg);
    assign q_eff      = (forced_eff || tq_reg == '0) ? QB'(1) : tq_reg;
    assign rem_dec    = (rem_rd != '0) ? rem_rd - TB'(1) : '0;

    // result arithmetic
    logic [TB:0]   fin, arr_x, ta_x;
    logic [TB-1:0] ta, wt, run_bur;
    assign fin     = {1'b0, tick_reg} + (TB+1)'(1);
    assign arr_x   = {1'b0, arr_mem[run_slot_reg]};
    assign run_bur = bur_mem[run_slot_reg];
    assign ta_x    = (fin >= arr_x) ? fin - arr_x : '0;
    assign ta      = ta_x[TB] ? {TB{1'b1}} : ta_x[TB-1:0];
    assign wt      = (ta >= run_bur) ? ta - run_bur : '0;

    // load removal positions
    logic [SB:0] rr_pos, lo_pos;
    assign rr_pos = find_slot(rr_list_reg, rr_cnt_reg, in_slot_reg);
    assign lo_pos = find_slot(lo_list_reg, lo_cnt_reg, in_slot_reg);

    // lower list with the chosen entry moved to the back
    tlrs_pkg::slot_list_t lo_requeue;
    always_comb begin
        lo_requeue = drop_at(lo_list_reg, best_idx_reg);
        lo_requeue[lo_cnt_reg[SB-1:0] - SB'(1)] = run_slot_reg;
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    assign st.is_tick   = s_tuser;
    assign st.scan_hit  = scan_in && !mask_reg[scan_idx_reg] &&
                          ({1'b0, scan_arr} <= t_cmp) && (scan_rem != '0);
    assign st.scan_end  = ({1'b0, scan_idx_reg} + CB'(1) >= n_eff);
    assign st.rr_any    = (rr_cnt_reg != '0);
    assign st.low_any   = (lo_cnt_reg != '0);
    assign st.slice_hit = (slice_reg >= q_eff);
    assign st.min_end   = (min_idx_reg >= lo_cnt_reg);
    assign st.out_free  = out_free;

    assign m_tdata  = out_reg;
    assign m_tvalid = m_valid_reg;

    // stores and payload
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            in_slot_reg <= s_tdata[SB-1:0];
            in_arr_reg  <= s_tdata[SB+TB-1:SB];
            in_bur_reg  <= s_tdata[SB+2*TB-1:SB+TB];
        end
        if (cmd.load) begin
            arr_mem[in_slot_reg] <= in_arr_reg;
            bur_mem[in_slot_reg] <= in_bur_reg;
            rem_mem[in_slot_reg] <= in_bur_reg;
        end
        if (cmd.rr_run || cmd.low_run) begin
            rem_mem[rem_addr] <= rem_dec;
            run_slot_reg      <= rem_addr;
            done_reg          <= (rem_dec == '0);
            from_low_reg      <= cmd.low_run;
            shit_reg          <= (slice_reg >= q_eff);
        end
        if (cmd.min_init) begin
            min_idx_reg  <= CB'(1);
            best_idx_reg <= '0;
            best_val_reg <= rem_rd;
        end else if (cmd.min_step) begin
            min_idx_reg <= min_idx_reg + CB'(1);
            if (rem_rd < best_val_reg) begin
                best_idx_reg <= min_idx_reg[SB-1:0];
                best_val_reg <= rem_rd;
            end
        end
        if (cmd.scan_init) begin
            late_reg <= cmd.scan_late;
        end
        if (cmd.res) begin
            out_reg <= {1'b0, (done_reg ? wt : TB'(0)), (done_reg ? ta : TB'(0)),
                        done_reg, from_low_reg, 1'b0, run_slot_reg};
        end else if (cmd.res_idle) begin
            out_reg <= {1'b0, {TB{1'b0}}, {TB{1'b0}}, 1'b0, 1'b0, 1'b1, {SB{1'b0}}};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= '0;
            rr_list_reg  <= '0;
            lo_list_reg  <= '0;
            rr_cnt_reg   <= '0;
            lo_cnt_reg   <= '0;
            slice_reg    <= QB'(1);
            forced_reg   <= 1'b0;
            lran_reg     <= 1'b0;
            tick_reg     <= '0;
            tq_reg       <= QB'(2);
            pc_reg       <= tlrs_pkg::PC_BITS'(NS);
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_we) begin
                case (cfg_addr)
                    tlrs_pkg::REG_QUANTUM: tq_reg <= cfg_wdata;
                    tlrs_pkg::REG_PCOUNT:  pc_reg <= cfg_wdata[tlrs_pkg::PC_BITS-1:0];
                    default: ;
                endcase
            end

            // reload: drop slot from both levels
            if (cmd.load) begin
                mask_reg[in_slot_reg] <= 1'b0;
                if (rr_pos[SB]) begin
                    rr_list_reg <= drop_at(rr_list_reg, rr_pos[SB-1:0]);
                    rr_cnt_reg  <= rr_cnt_reg - CB'(1);
                end
                if (lo_pos[SB]) begin
                    lo_list_reg <= drop_at(lo_list_reg, lo_pos[SB-1:0]);
                    lo_cnt_reg  <= lo_cnt_reg - CB'(1);
                end
            end

            // admission scan
            if (cmd.scan_init) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + SB'(1);
                if (st.scan_hit) begin
                    rr_list_reg[rr_cnt_reg[SB-1:0]] <= scan_idx_reg;
                    rr_cnt_reg                      <= rr_cnt_reg + CB'(1);
                    mask_reg[scan_idx_reg]          <= 1'b1;
                end
            end

            // level flags
            if (cmd.rr_run) begin
                forced_reg <= forced_eff;
                lran_reg   <= 1'b0;
            end
            if (cmd.low_run) begin
                lran_reg <= 1'b1;
            end

            // list and slice bookkeeping
            if (cmd.upd) begin
                if (shit_reg || done_reg) begin
                    slice_reg <= QB'(1);
                end else if (slice_reg != {QB{1'b1}}) begin
                    slice_reg <= slice_reg + QB'(1);
                end
                if (from_low_reg) begin
                    if (shit_reg && !done_reg) begin
                        lo_list_reg <= lo_requeue;
                    end else if (shit_reg || done_reg) begin
                        lo_list_reg <= drop_at(lo_list_reg, best_idx_reg);
                        lo_cnt_reg  <= lo_cnt_reg - CB'(1);
                    end
                end else if (shit_reg || done_reg) begin
                    rr_list_reg <= drop_at(rr_list_reg, '0);
                    rr_cnt_reg  <= rr_cnt_reg - CB'(1);
                    if (shit_reg && !done_reg) begin
                        lo_list_reg[lo_cnt_reg[SB-1:0]] <= run_slot_reg;
                        lo_cnt_reg                      <= lo_cnt_reg + CB'(1);
                    end
                end
            end

            // result beat and tick advance
            if (cmd.res || cmd.res_idle) begin
                m_valid_reg <= 1'b1;
                tick_reg    <= tick_reg + TB'(1);
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/two_level_rr_srtf_scheduler_unit.sv =====
// Two-level tick scheduler: round-robin upper level over a
// shortest-remaining lower level, for up to 16 process slots.
// Input channel (s_*): one beat per item. s_tuser = 0 loads a slot
// (index, arrival, burst); s_tuser = 1 advances one tick.
// Result channel (m_*): one beat per tick item, none per load.
// Configuration: cfg_we/cfg_addr/cfg_wdata, index 0 time quantum,
// index 1 process count; write only while the block is idle.
// Sequence: a load is accepted, then applied. A tick is accepted, then an
// admission scan runs one slot per cycle, followed by a select step,
// then either a run plus a second scan when a round-robin slice ends,
// or a search of one lower-level entry per cycle and a run, then
// bookkeeping and result steps. An idle tick goes from select to its result.
// The result appears in an output register; the input side accepts the
// next beat while that result still waits.
// Reset (aresetn low, synchronous) empties both levels, clears the
// admitted set and the tick counter, and restores quantum 2 and count 16.
// When the receiver stalls, the next tick holds in its last cycle until
// the output register is free.
module two_level_rr_srtf_scheduler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] slot_index, [19:4] arrival, [35:20] burst, [39:36] zero
    input  logic [39:0] s_tdata,
    // [0] action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] run_slot, [4] idle, [5] from_lower, [6] finished,
    // [22:7] turnaround, [38:23] wait_time, [39] zero
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    tlrs_pkg::cmd_t    cmd;
    tlrs_pkg::status_t st;

    tlrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tlrs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam int   CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [3:0]  run_slot;
        logic        idle;
        logic        from_lower;
        logic        finished;
        logic [15:0] turnaround;
        logic [15:0] wait_time;
    } tick_res_t;

    // scheduler predictor plus queue of expected tick results
    class sched_scoreboard;
        logic [15:0] arr[tlrs_pkg::MAX_SLOTS];
        logic [15:0] bst[tlrs_pkg::MAX_SLOTS];
        logic [15:0] rem[tlrs_pkg::MAX_SLOTS];
        logic [tlrs_pkg::MAX_SLOTS-1:0] admitted;
        int unsigned rrq[$];
        int unsigned lowq[$];
        int unsigned slice;
        bit forced_one;
        bit lower_ran;
        logic [15:0] now;
        logic [7:0] quantum;
        logic [4:0] pcount;
        tick_res_t pending[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned finishes;
        int unsigned lower_runs;

        function new();
            for (int i = 0; i < tlrs_pkg::MAX_SLOTS; i++) begin
                arr[i] = '0; bst[i] = '0; rem[i] = '0;
            end
            admitted = '0; slice = 1; forced_one = 0; lower_ran = 0;
            now = '0; quantum = 8'd2; pcount = 5'd16;
            errors = 0; checked = 0; finishes = 0; lower_runs = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] v);
            if (idx == tlrs_pkg::REG_QUANTUM) quantum = v;
            else pcount = v[4:0];
        endfunction

        function void purge(ref int unsigned q[$], input int unsigned s);
            for (int i = q.size() - 1; i >= 0; i--) if (q[i] == s) q.delete(i);
        endfunction

        // admit lowest-index arrived slot with work
        function void admit_one(logic [16:0] t);
            int unsigned n;
            n = (pcount > tlrs_pkg::MAX_SLOTS) ? tlrs_pkg::MAX_SLOTS : int'(pcount);
            for (int p = 0; p < n; p++) begin
                if (!admitted[p] && {1'b0, arr[p]} <= t && rem[p] != 0) begin
                    if (rrq.size() < tlrs_pkg::MAX_SLOTS) rrq.insert(rrq.size(), p);
                    admitted[p] = 1'b1;
                    return;
                end
            end
        endfunction

        function void note_input(logic act, logic [39:0] d);
            int unsigned s, bi, q;
            bit done, lower, slice_end;
            logic [16:0] fin, ta;
            tick_res_t r;
            if (act == ACT_LOAD) begin
                s = int'(d[3:0]);
                arr[s] = d[19:4]; bst[s] = d[35:20]; rem[s] = d[35:20];
                admitted[s] = 1'b0;
                purge(rrq, s); purge(lowq, s);
                return;
            end
            r = '0;
            admit_one({1'b0, now});
            if (rrq.size() == 0 && lowq.size() == 0) begin
                r.idle = 1'b1;
                pending.insert(pending.size(), r);
                now = now + 16'd1;
                return;
            end
            lower = (rrq.size() == 0);
            if (!lower && lower_ran) begin
                forced_one = 1; lower_ran = 0;
            end
            if (lower) lower_ran = 1;
            q = (forced_one || quantum == 0) ? 1 : int'(quantum);
            if (lower) begin
                bi = 0;
                for (int i = 1; i < lowq.size(); i++)
                    if (rem[lowq[i]] < rem[lowq[bi]]) bi = i;
                s = lowq[bi];
            end else s = rrq[0];
            if (rem[s] != 0) rem[s] = rem[s] - 16'd1;
            done = (rem[s] == 0);
            slice_end = (slice >= q);
            if (slice_end) begin
                if (lower) begin
                    lowq.delete(bi);
                    if (!done) lowq.insert(lowq.size(), s);
                end else begin
                    admit_one({1'b0, now} + 17'd1);
                    void'(rrq.pop_front());
                    if (!done && lowq.size() < tlrs_pkg::MAX_SLOTS)
                        lowq.insert(lowq.size(), s);
                end
                slice = 1;
            end else if (done) begin
                if (lower) lowq.delete(bi); else void'(rrq.pop_front());
                slice = 1;
            end else if (slice < 255) slice++;
            r.run_slot = 4'(s);
            r.from_lower = lower;
            r.finished = done;
            if (done) begin
                fin = {1'b0, now} + 17'd1;
                ta = (fin >= {1'b0, arr[s]}) ? fin - {1'b0, arr[s]} : 17'd0;
                if (ta > 17'hFFFF) ta = 17'hFFFF;
                r.turnaround = ta[15:0];
                r.wait_time = (ta[15:0] >= bst[s]) ? ta[15:0] - bst[s] : 16'd0;
                finishes++;
            end
            if (lower) lower_runs++;
            pending.insert(pending.size(), r);
            now = now + 16'd1;
        endfunction

        function void check_result(logic [39:0] d);
            tick_res_t got, exp;
            got = tick_res_t'({d[3:0], d[4], d[5], d[6], d[22:7], d[38:23]});
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", d);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp || d[39] !== 1'b0) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch at result %0d: exp slot=%0d idle=%b low=%b fin=%b ta=%0d wt=%0d",
                             checked, exp.run_slot, exp.idle, exp.from_lower,
                             exp.finished, exp.turnaround, exp.wait_time);
                    $display("    got slot=%0d idle=%b low=%b fin=%b ta=%0d wt=%0d",
                             got.run_slot, got.idle, got.from_lower, got.finished,
                             got.turnaround, got.wait_time);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    sched_scoreboard sb;
    int unsigned cycles = 0;
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;
    bit long_hold = 0;

    always #5 aclk = ~aclk;

    two_level_rr_srtf_scheduler_unit dut (.*);

    // timeout watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: accepted beats go to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver stall pattern, with one long hold-off
    always @(negedge aclk) begin
        if (long_hold) m_tready <= 1'b0;
        else if (cycles % 512 < 150) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        wait (aresetn);
        wait (beats_sent > 900);
        @(negedge aclk);
        long_hold = 1;
        repeat (300) @(negedge aclk);
        long_hold = 0;
    end

    task automatic send_beat(logic act, logic [3:0] s, logic [15:0] a, logic [15:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, b, a, s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(act, {4'b0, b, a, s});
        beats_sent++;
        burst_left--;
        @(negedge aclk);
        if (burst_left == 0) s_tvalid <= 1'b0;
    endtask

    task automatic tick();
        send_beat(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic load(logic [3:0] s, logic [15:0] a, logic [15:0] b);
        send_beat(ACT_LOAD, s, a, b);
    endtask

    // drain expected results, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] v);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // one scenario: load a set of slots, mostly relative to now, then tick with occasional loads
    task automatic scenario(int unsigned nslots, int unsigned nticks, int unsigned maxb);
        logic [15:0] base;
        for (int i = 0; i < nslots; i++) begin
            base = sb.now;
            if ($urandom_range(0, 9) == 0) load(4'($urandom), 16'($urandom), 16'($urandom));
            else load(4'($urandom_range(0, 15)), 16'(base + $urandom_range(0, 12)),
                      $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(1, maxb)));
        end
        for (int i = 0; i < nticks; i++) begin
            tick();
            if ($urandom_range(0, 30) == 0) load(4'($urandom),
                                                 16'(sb.now + $urandom_range(0, 4)),
                                                 16'($urandom_range(1, maxb)));
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // give every slot a defined entry with no work
        for (int i = 0; i < tlrs_pkg::MAX_SLOTS; i++) load(4'(i), 16'd0, 16'd0);

        // directed: idle ticks, extremes, reload, zero burst, ties
        tick();
        load(4'd0, 16'd0, 16'd3);
        load(4'd15, 16'd0, 16'd3);
        load(4'd5, 16'd1, 16'd0);
        load(4'd7, 16'hFFFF, 16'hFFFF);
        load(4'd3, 16'd0, 16'd5);
        load(4'd3, 16'd2, 16'd4);
        for (int i = 0; i < 14; i++) tick();
        drain();

        write_reg(tlrs_pkg::REG_QUANTUM, 8'd0);
        write_reg(tlrs_pkg::REG_PCOUNT, 8'd0);
        load(4'd1, 16'd0, 16'd2);
        tick(); tick();
        drain();
        write_reg(tlrs_pkg::REG_PCOUNT, 8'd31);
        write_reg(tlrs_pkg::REG_QUANTUM, 8'd255);
        scenario(4, 12, 6);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(tlrs_pkg::REG_QUANTUM, ph % 4 == 0 ? 8'd1 : ph % 4 == 1 ? 8'd255 :
                                   ph % 4 == 2 ? 8'd0 : 8'($urandom_range(2, 6)));
            write_reg(tlrs_pkg::REG_PCOUNT, ph % 3 == 0 ? 8'd16 : ph % 3 == 1 ? 8'd1 :
                                  8'($urandom_range(0, 31)));
            for (int k = 0; k < 7; k++) scenario($urandom_range(2, 8), $urandom_range(6, 25), 10);
            drain();
        end

        drain();
        repeat (100) @(negedge aclk);
        $display("summary: %0d beats in, %0d results checked, %0d finishes, %0d lower-level runs",
                 beats_sent, sb.checked, sb.finishes, sb.lower_runs);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("errors: %0d, left over: %0d", sb.errors, sb.pending.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
